### rtl/smeu_pkg.sv
// package for the stack machine execute unit
// shared sizes, command and status codes, queue entry types; no dependencies
`timescale 1ns / 1ps

package smeu_pkg;

  localparam int STACK_DEPTH  = 64;
  localparam int PROGRAM_SIZE = 1024;
  localparam int WORD_W       = 32;
  localparam int PC_W         = $clog2(PROGRAM_SIZE);
  localparam int DEPTH_W      = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W       = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_READ   = 4'd1,
    CMD_WRITE  = 4'd2,
    CMD_PUSH   = 4'd3,
    CMD_DUP    = 4'd4,
    CMD_JUMPIF = 4'd5,
    CMD_MUL    = 4'd6,
    CMD_SWAP   = 4'd7,
    CMD_OVER   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // decoded instruction as it waits between front and back
  typedef struct packed {
    cmd_t                     op;
    logic                     known;
    logic [1:0]               need;
    logic                     grows;
    logic signed [WORD_W-1:0] imm;
    logic signed [WORD_W-1:0] rd;
  } instr_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     write_valid;
    logic signed [WORD_W-1:0] write_value;
    status_t                  status;
    logic [DEPTH_W-1:0]       depth;
  } result_t;

endpackage

### rtl/stack_machine_execute_unit.sv
// Stack machine execute unit: runs one instruction per transfer on a 64-entry stack of
// 32-bit words and returns one result per instruction. Sustained rate is one instruction
// per clock while the result queue has room: the top two stack entries sit in flops and the
// third is prefetched from a one-write one-read memory every cycle, so no instruction waits on
// the one before it. An instruction transfer is decoded into a two-entry queue and executed
// once it heads that queue and the result queue has room. Its result is registered into the
// result queue and shown on the result ports from there. Both sides can stall independently.
// With no pops, four instructions are taken before full rises: two results wait in the result
// queue and two decoded instructions wait in front of the back end. Reads of the unused stack
// area need no clearing after reset.
// depends on smeu_pkg, smeu_front, smeu_back, smeu_result_queue
`timescale 1ns / 1ps

module stack_machine_execute_unit import smeu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [3:0]                command,
  input  logic signed [WORD_W-1:0]  immediate,
  input  logic signed [WORD_W-1:0]  read_value,
  output logic                      empty,
  input  logic                      pop,
  output logic [PC_W-1:0]           next_pc,
  output logic                      write_valid,
  output logic signed [WORD_W-1:0]  write_value,
  output logic [1:0]                status,
  output logic [DEPTH_W-1:0]        depth
);

  logic    instr_valid;
  instr_t  instr;
  logic    instr_take;
  logic    res_ready;
  logic    res_push;
  result_t res;
  result_t res_out;

  smeu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .immediate   (immediate),
    .read_value  (read_value),
    .instr_valid (instr_valid),
    .instr       (instr),
    .instr_take  (instr_take)
  );

  smeu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr       (instr),
    .instr_take  (instr_take),
    .res_ready   (res_ready),
    .res_push    (res_push),
    .res         (res)
  );

  smeu_result_queue u_result_queue (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res_in    (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .res_out   (res_out)
  );

  assign next_pc     = res_out.next_pc;
  assign write_valid = res_out.write_valid;
  assign write_value = res_out.write_value;
  assign status      = res_out.status;
  assign depth       = res_out.depth;

endmodule

### rtl/smeu_front.sv
// front end: decodes each incoming instruction and holds it in a two-entry queue
// depends on smeu_pkg
`timescale 1ns / 1ps

module smeu_front import smeu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [3:0]               command,
  input  logic signed [WORD_W-1:0] immediate,
  input  logic signed [WORD_W-1:0] read_value,
  output logic                     instr_valid,
  output instr_t                   instr,
  input  logic                     instr_take
);

  instr_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  instr_t     dec;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    dec       = '0;
    dec.op    = cmd_t'(command);
    dec.imm   = immediate;
    dec.rd    = read_value;
    dec.known = 1'b1;
    case (command) inside
      CMD_ADD, CMD_MUL, CMD_SWAP: begin
        dec.need = 2'd2;
      end
      CMD_OVER: begin
        dec.need  = 2'd2;
        dec.grows = 1'b1;
      end
      CMD_WRITE, CMD_JUMPIF: begin
        dec.need = 2'd1;
      end
      CMD_DUP: begin
        dec.need  = 2'd1;
        dec.grows = 1'b1;
      end
      CMD_READ, CMD_PUSH: begin
        dec.grows = 1'b1;
      end
      default: begin
        dec.known = 1'b0;
      end
    endcase
  end

  assign full        = (count == 2'd2);
  assign instr_valid = (count != 2'd0);
  assign instr       = slot[rd_ptr];
  assign do_push     = push && !full;
  assign do_pop      = instr_take && instr_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### rtl/smeu_back.sv
// back end: executes one decoded instruction per cycle on the operand stack while the result queue has room;
// top two entries in flops, deeper entries in a memory; depends on smeu_pkg
`timescale 1ns / 1ps

module smeu_back import smeu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    instr_valid,
  input  instr_t  instr,
  output logic    instr_take,
  input  logic    res_ready,
  output logic    res_push,
  output result_t res
);

  logic [WORD_W-1:0]   stack_mem [STACK_DEPTH];
  logic [WORD_W-1:0]   top;
  logic [WORD_W-1:0]   second;
  logic [WORD_W-1:0]   third;
  logic [DEPTH_W-1:0]  count;
  logic [PC_W-1:0]     pc;

  logic [WORD_W-1:0]   top_next;
  logic [WORD_W-1:0]   second_next;
  logic [DEPTH_W-1:0]  count_next;
  logic [PC_W-1:0]     pc_next;
  logic [PC_W-1:0]     pc_step;
  logic [2*WORD_W-1:0] prod;
  logic                fire;
  logic                under;
  logic                over;
  logic                exec;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [DEPTH_W-1:0]  waddr_wide;
  logic [DEPTH_W-1:0]  raddr_wide;

  assign fire       = instr_valid && res_ready;
  assign instr_take = fire;
  assign res_push   = fire;

  assign under   = (count < DEPTH_W'(instr.need));
  assign over    = instr.grows && (count >= DEPTH_W'(STACK_DEPTH));
  assign exec    = fire && instr.known && !under && !over;
  assign pc_step = (pc == PC_W'(PROGRAM_SIZE - 1)) ? '0 : pc + PC_W'(1);
  assign prod    = top * second;

  always_comb begin
    top_next    = top;
    second_next = second;
    count_next  = count;
    pc_next     = pc;
    mem_we      = 1'b0;
    if (exec) begin
      pc_next = pc_step;
      case (instr.op)
        CMD_ADD: begin
          top_next    = top + second;
          second_next = third;
          count_next  = count - DEPTH_W'(1);
        end
        CMD_MUL: begin
          top_next    = prod[WORD_W-1:0];
          second_next = third;
          count_next  = count - DEPTH_W'(1);
        end
        CMD_SWAP: begin
          top_next    = second;
          second_next = top;
        end
        CMD_OVER: begin
          top_next    = second;
          second_next = top;
          count_next  = count + DEPTH_W'(1);
          mem_we      = 1'b1;
        end
        CMD_DUP: begin
          second_next = top;
          count_next  = count + DEPTH_W'(1);
          mem_we      = (count >= DEPTH_W'(2));
        end
        CMD_READ, CMD_PUSH: begin
          top_next    = (instr.op == CMD_READ) ? instr.rd : instr.imm;
          second_next = top;
          count_next  = count + DEPTH_W'(1);
          mem_we      = (count >= DEPTH_W'(2));
        end
        CMD_WRITE: begin
          top_next    = second;
          second_next = third;
          count_next  = count - DEPTH_W'(1);
        end
        CMD_JUMPIF: begin
          top_next    = second;
          second_next = third;
          count_next  = count - DEPTH_W'(1);
          if (!top[WORD_W-1]) begin
            pc_next = instr.imm[PC_W-1:0];
          end
        end
        default: begin
          pc_next = pc;
        end
      endcase
    end
  end

  // second spills to entry count-2; third tracks entry count-3
  assign waddr_wide = count - DEPTH_W'(2);
  assign raddr_wide = count_next - DEPTH_W'(3);
  assign mem_waddr  = waddr_wide[ADDR_W-1:0];
  assign mem_raddr  = raddr_wide[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= second;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      third <= second;
    end else begin
      third <= stack_mem[mem_raddr];
    end
    top    <= top_next;
    second <= second_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pc    <= '0;
    end else begin
      count <= count_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    res             = '0;
    res.next_pc     = pc_next;
    res.depth       = count_next;
    res.write_valid = exec && (instr.op == CMD_WRITE);
    res.write_value = res.write_valid ? top : '0;
    if (!instr.known) begin
      res.status = ST_OK;
    end else if (under) begin
      res.status = ST_UNDER;
    end else if (over) begin
      res.status = ST_OVER;
    end else begin
      res.status = ST_OK;
    end
  end

endmodule

### rtl/smeu_result_queue.sv
// two-entry result queue between the back end and the result ports
// depends on smeu_pkg
`timescale 1ns / 1ps

module smeu_result_queue import smeu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res_in,
  output logic    res_ready,
  output logic    empty,
  input  logic    pop,
  output result_t res_out
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign empty     = (count == 2'd0);
  assign do_pop    = pop && !empty;
  assign res_ready = (count != 2'd2) || do_pop;
  assign do_push   = res_push && res_ready;
  assign res_out   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
